// ----- hdl/assert_macros.svh -----
// Assertion macros used by the terminal line buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TLB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("terminal line buffer assertion failed");

`define TLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("terminal line buffer assertion failed");

`else

`define TLB_ASSERT_IMPL(label, clk, rst, ante, cons)

`define TLB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/tlb_pkg.sv -----
// Constants, types and helpers shared by the terminal line buffer modules.
`default_nettype none

package tlb_pkg;

   localparam int LINES_MAX  = 256;
   localparam int LINE_WIDTH = 64;

   localparam int SLOT_W  = (LINES_MAX > 1) ? $clog2(LINES_MAX) : 1;
   localparam int COUNT_W = $clog2(LINES_MAX + 1);
   localparam int LEN_W   = $clog2(LINE_WIDTH + 1);
   localparam int COL_W   = 6;
   localparam int ADDR_W  = $clog2(LINES_MAX * LINE_WIDTH);

   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd126;

   localparam int TAB_SPACES = 4;
   localparam int TAB_CNT_W  = $clog2(TAB_SPACES);

   localparam logic MODE_APPLY = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic                  text_we;
      logic [ADDR_W-1:0]     text_waddr;
      logic [7:0]            text_wdata;
      logic [ADDR_W-1:0]     text_raddr;
      logic                  len_we;
      logic [SLOT_W-1:0]     len_waddr;
      logic [LEN_W-1:0]      len_wdata;
      logic [SLOT_W-1:0]     len_raddr;
   } mem_req_type;

   function automatic logic [ADDR_W-1:0] text_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(ADDR_W'(slot) * ADDR_W'(LINE_WIDTH)) + ADDR_W'(col);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
      return (slot == SLOT_W'(LINES_MAX - 1)) ? '0 : slot + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] slot);
      return (slot == '0) ? SLOT_W'(LINES_MAX - 1) : slot - 1'b1;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/terminal_line_buffer.sv -----
// Top level of the terminal line buffer: command sequencer and line bookkeeping.
//
// The block keeps a scrollback of text lines for a serial terminal. A word is
// issued by raising start while busy is low, with req_mode selecting what to do:
// mode 0 applies req_data_byte to the text (CR, LF, backspace, delete, tab and
// printable bytes), mode 1 reads the character at req_read_line / req_read_col.
// Every accepted word gives exactly one result word, shown for a single cycle
// with rsp_valid high; it carries the read character and line length (zero for
// apply words) and the line count, cursor column and dropped line total after
// the word. The receiver cannot stall; results are never held.
// A word passes through the states EXEC, TAB (tab only, one per further space)
// and FIN; rsp_valid is registered from FIN. busy is low again in the rsp_valid
// cycle, so a new word is only taken once the last one is through. The text
// memory has one write port (one character per cycle) and a registered read.
// Reset leaves one empty line, a zero dropped total and no result pending. No
// memory clearing is needed: a character is only read below its line's length.
`default_nettype none

`include "assert_macros.svh"

module terminal_line_buffer
   import tlb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_read_line,
   input  wire logic [5:0]  req_read_col,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_char,
   output logic [6:0]       rsp_read_line_length,
   output logic [8:0]       rsp_line_count,
   output logic [6:0]       rsp_cursor_col,
   output logic [31:0]      rsp_dropped_total
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_TAB  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                 mode_ff, mode_in;
   logic [7:0]           byte_ff, byte_in;
   logic [7:0]           rline_ff, rline_in;
   logic [COL_W-1:0]     rcol_ff, rcol_in;

   logic [SLOT_W-1:0]    oldest_ff, oldest_in;
   logic [SLOT_W-1:0]    newest_ff, newest_in;
   logic [COUNT_W-1:0]   kept_ff, kept_in;
   logic [LEN_W-1:0]     cur_len_ff, cur_len_in;
   logic                 cr_ff, cr_in;
   logic [31:0]          dropped_ff, dropped_in;
   logic [TAB_CNT_W-1:0] tab_cnt_ff, tab_cnt_in;
   logic                 pop_ff, pop_in;
   logic                 rd_hit_ff, rd_hit_in;
   logic                 rd_newest_ff, rd_newest_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic [6:0]           rsp_len_ff, rsp_len_in;
   logic [8:0]           rsp_count_ff, rsp_count_in;
   logic [6:0]           rsp_cursor_ff, rsp_cursor_in;
   logic [31:0]          rsp_dropped_ff, rsp_dropped_in;

   mem_req_type          mem_req;
   logic [7:0]           text_rdata;
   logic [LEN_W-1:0]     len_rdata;

   logic [SLOT_W:0]      rd_sum;
   logic [SLOT_W-1:0]    rd_slot;
   logic                 rd_in_range;
   logic [LEN_W-1:0]     rd_len;

   tlb_mem u_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .text_rdata (text_rdata),
      .len_rdata  (len_rdata)
   );

   always_comb begin
      rd_sum      = (SLOT_W + 1)'(oldest_ff) + (SLOT_W + 1)'(rline_ff[SLOT_W-1:0]);
      rd_slot     = (rd_sum >= (SLOT_W + 1)'(LINES_MAX)) ?
                    SLOT_W'(rd_sum - (SLOT_W + 1)'(LINES_MAX)) : SLOT_W'(rd_sum);
      rd_in_range = (9'(rline_ff) < 9'(kept_ff));
      rd_len      = rd_newest_ff ? cur_len_ff : len_rdata;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      byte_in        = byte_ff;
      rline_in       = rline_ff;
      rcol_in        = rcol_ff;
      oldest_in      = oldest_ff;
      newest_in      = newest_ff;
      kept_in        = kept_ff;
      cur_len_in     = cur_len_ff;
      cr_in          = cr_ff;
      dropped_in     = dropped_ff;
      tab_cnt_in     = tab_cnt_ff;
      pop_in         = pop_ff;
      rd_hit_in      = rd_hit_ff;
      rd_newest_in   = rd_newest_ff;
      rsp_valid_in   = 1'b0;
      rsp_char_in    = rsp_char_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_cursor_in  = rsp_cursor_ff;
      rsp_dropped_in = rsp_dropped_ff;

      mem_req            = '0;
      mem_req.text_raddr = text_addr(rd_slot, rcol_ff);
      mem_req.text_wdata = BYTE_SPACE;
      mem_req.text_waddr = text_addr(newest_ff, COL_W'(cur_len_ff));
      mem_req.len_raddr  = rd_slot;
      mem_req.len_waddr  = newest_ff;
      mem_req.len_wdata  = cur_len_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               byte_in  = req_data_byte;
               rline_in = req_read_line;
               rcol_in  = req_read_col;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_FIN;
            if (mode_ff == MODE_READ) begin
               rd_hit_in    = rd_in_range;
               rd_newest_in = (rd_slot == newest_ff);
            end else if (byte_ff == BYTE_CR || (byte_ff == BYTE_LF && !cr_ff)) begin
               // A new line: save the current length and open the next slot.
               cr_in          = (byte_ff == BYTE_CR);
               mem_req.len_we = 1'b1;
               newest_in      = slot_next(newest_ff);
               cur_len_in     = '0;
               if (kept_ff < COUNT_W'(LINES_MAX)) begin
                  kept_in = kept_ff + 1'b1;
               end else begin
                  oldest_in = slot_next(oldest_ff);
                  if (dropped_ff != 32'hFFFF_FFFF) begin
                     dropped_in = dropped_ff + 32'd1;
                  end
               end
            end else if (byte_ff == BYTE_LF) begin
               cr_in = 1'b0;
            end else begin
               cr_in = 1'b0;
               if (byte_ff == BYTE_BS || byte_ff == BYTE_DEL) begin
                  if (cur_len_ff != '0) begin
                     cur_len_in = cur_len_ff - 1'b1;
                  end else if (kept_ff > COUNT_W'(1)) begin
                     kept_in           = kept_ff - 1'b1;
                     newest_in         = slot_prev(newest_ff);
                     mem_req.len_raddr = slot_prev(newest_ff);
                     pop_in            = 1'b1;
                  end
               end else if (byte_ff == BYTE_TAB ||
                            (byte_ff >= PRINT_LO && byte_ff <= PRINT_HI)) begin
                  if (cur_len_ff < LEN_W'(LINE_WIDTH)) begin
                     mem_req.text_we    = 1'b1;
                     mem_req.text_wdata = (byte_ff == BYTE_TAB) ? BYTE_SPACE : byte_ff;
                     cur_len_in         = cur_len_ff + 1'b1;
                  end
                  if (byte_ff == BYTE_TAB) begin
                     tab_cnt_in = TAB_CNT_W'(TAB_SPACES - 1);
                     state_in   = ST_TAB;
                  end
               end
            end
         end

         ST_TAB: begin
            if (cur_len_ff < LEN_W'(LINE_WIDTH)) begin
               mem_req.text_we = 1'b1;
               cur_len_in      = cur_len_ff + 1'b1;
            end
            tab_cnt_in = tab_cnt_ff - 1'b1;
            if (tab_cnt_ff == TAB_CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            rsp_valid_in   = 1'b1;
            rsp_count_in   = 9'(kept_ff);
            rsp_dropped_in = dropped_ff;
            rsp_cursor_in  = 7'(cur_len_ff);
            rsp_char_in    = '0;
            rsp_len_in     = '0;
            if (pop_ff) begin
               cur_len_in    = len_rdata;
               rsp_cursor_in = 7'(len_rdata);
            end
            if (rd_hit_ff) begin
               rsp_len_in = 7'(rd_len);
               if (7'(rcol_ff) < 7'(rd_len)) begin
                  rsp_char_in = text_rdata;
               end
            end
            pop_in    = 1'b0;
            rd_hit_in = 1'b0;
            state_in  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         kept_ff      <= COUNT_W'(1);
         cur_len_ff   <= '0;
         cr_ff        <= 1'b0;
         dropped_ff   <= '0;
         tab_cnt_ff   <= '0;
         pop_ff       <= 1'b0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         kept_ff      <= kept_in;
         cur_len_ff   <= cur_len_in;
         cr_ff        <= cr_in;
         dropped_ff   <= dropped_in;
         tab_cnt_ff   <= tab_cnt_in;
         pop_ff       <= pop_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      byte_ff        <= byte_in;
      rline_ff       <= rline_in;
      rcol_ff        <= rcol_in;
      rd_newest_ff   <= rd_newest_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_cursor_ff  <= rsp_cursor_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_char        = rsp_char_ff;
   assign rsp_read_line_length = rsp_len_ff;
   assign rsp_line_count       = rsp_count_ff;
   assign rsp_cursor_col       = rsp_cursor_ff;
   assign rsp_dropped_total    = rsp_dropped_ff;

   `TLB_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_line_count - 9'd1 < 9'(LINES_MAX))
   `TLB_ASSERT_IMPL(a_cursor_range, clock, reset, 1'b1, cur_len_ff <= LEN_W'(LINE_WIDTH))
   `TLB_ASSERT_NEXT(a_no_early_rsp, clock, reset, start && !busy, !rsp_valid && busy)
   `TLB_ASSERT_NEXT(a_dropped_monotonic, clock, reset, 1'b1, dropped_ff >= $past(dropped_ff))

endmodule

`default_nettype wire

// ----- hdl/tlb_mem.sv -----
// Text store and line length memories, one write and one registered read each.
`default_nettype none

module tlb_mem
   import tlb_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_req_type       mem_req,
   output logic [7:0]             text_rdata,
   output logic [LEN_W-1:0]       len_rdata
);

   logic [7:0]       text_mem [LINES_MAX * LINE_WIDTH];
   logic [LEN_W-1:0] len_mem  [LINES_MAX];

   always_ff @(posedge clock) begin
      if (mem_req.text_we) begin
         text_mem[mem_req.text_waddr] <= mem_req.text_wdata;
      end
      text_rdata <= text_mem[mem_req.text_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_req.len_we) begin
         len_mem[mem_req.len_waddr] <= mem_req.len_wdata;
      end
      len_rdata <= len_mem[mem_req.len_raddr];
   end

endmodule

`default_nettype wire

// ----- test/terminal_line_buffer_checker.sv -----
// Checker for the terminal line buffer: predicts each result word and compares it.
module terminal_line_buffer_checker
   import tlb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_read_line,
   input  logic [5:0]  req_read_col,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_read_char,
   input  logic [6:0]  rsp_read_line_length,
   input  logic [8:0]  rsp_line_count,
   input  logic [6:0]  rsp_cursor_col,
   input  logic [31:0] rsp_dropped_total,
   output int          mismatch_count,
   output int          words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  ch;
      logic [6:0]  line_len;
      logic [8:0]  count;
      logic [6:0]  cursor;
      logic [31:0] dropped;
   } screen_word_type;

   logic [7:0]      text_mem [0:LINES_MAX*LINE_WIDTH-1];
   int              line_len [0:LINES_MAX-1];
   int              oldest_slot;
   int              kept;
   logic            cr_armed;
   logic [31:0]     dropped;
   screen_word_type expected_words [$];
   int              mismatch_tally = 0;
   int              result_index = 0;

   initial begin
      mismatch_count = 0;
      words_in_flight = 0;
   end

   function automatic int slot_of_line(int logical);
      return (oldest_slot + logical) % LINES_MAX;
   endfunction

   function automatic void open_line();
      if (kept < LINES_MAX) begin
         kept++;
      end else begin
         oldest_slot = (oldest_slot + 1) % LINES_MAX;
         if (dropped != 32'hFFFF_FFFF) begin
            dropped++;
         end
      end
      line_len[slot_of_line(kept - 1)] = 0;
   endfunction

   function automatic void put_char(logic [7:0] ch);
      int s;
      int n;
      s = slot_of_line(kept - 1);
      n = line_len[s];
      if (n < LINE_WIDTH) begin
         text_mem[s * LINE_WIDTH + n] = ch;
         line_len[s] = n + 1;
      end
   endfunction

   function automatic void apply_received_byte(logic [7:0] data);
      int s;
      if (data == BYTE_CR) begin
         cr_armed = 1'b1;
         open_line();
      end else if (data == BYTE_LF) begin
         if (cr_armed) begin
            cr_armed = 1'b0;
         end else begin
            open_line();
         end
      end else begin
         cr_armed = 1'b0;
         if (data == BYTE_BS || data == BYTE_DEL) begin
            s = slot_of_line(kept - 1);
            if (line_len[s] != 0) begin
               line_len[s]--;
            end else if (kept > 1) begin
               kept--;
            end
         end else if (data == BYTE_TAB) begin
            for (int i = 0; i < TAB_SPACES; i++) begin
               put_char(BYTE_SPACE);
            end
         end else if (data >= PRINT_LO && data <= PRINT_HI) begin
            put_char(data);
         end
      end
   endfunction

   function automatic screen_word_type predict_screen_word(logic mode, logic [7:0] data,
                                                           logic [7:0] line,
                                                           logic [5:0] col);
      screen_word_type w;
      int s;
      w = '0;
      if (mode == MODE_APPLY) begin
         apply_received_byte(data);
      end else if (int'(line) < kept) begin
         s = slot_of_line(int'(line));
         w.line_len = 7'(line_len[s]);
         if (int'(col) < line_len[s]) begin
            w.ch = text_mem[s * LINE_WIDTH + int'(col)];
         end
      end
      w.count = 9'(kept);
      w.cursor = 7'(line_len[slot_of_line(kept - 1)]);
      w.dropped = dropped;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_tally++;
      $display("%0t: result word %0d, %0s is 0x%0h, predicted 0x%0h",
               $realtime, result_index, what, got, want);
   endtask

   always @(posedge clock) begin
      screen_word_type want;
      if (reset) begin
         for (int i = 0; i < LINES_MAX; i++) begin
            line_len[i] = 0;
         end
         oldest_slot = 0;
         kept = 1;
         cr_armed = 1'b0;
         dropped = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_line_count), 32'd0);
            end else begin
               want = expected_words[0];
               expected_words.delete(0);
               if (rsp_read_char !== want.ch) begin
                  report_mismatch("read_char", 32'(rsp_read_char), 32'(want.ch));
               end
               if (rsp_read_line_length !== want.line_len) begin
                  report_mismatch("read_line_length", 32'(rsp_read_line_length),
                                  32'(want.line_len));
               end
               if (rsp_line_count !== want.count) begin
                  report_mismatch("line_count", 32'(rsp_line_count), 32'(want.count));
               end
               if (rsp_cursor_col !== want.cursor) begin
                  report_mismatch("cursor_col", 32'(rsp_cursor_col), 32'(want.cursor));
               end
               if (rsp_dropped_total !== want.dropped) begin
                  report_mismatch("dropped_total", rsp_dropped_total, want.dropped);
               end
            end
            result_index++;
         end
         if (start && !busy) begin
            expected_words.insert(expected_words.size(),
                                  predict_screen_word(req_mode, req_data_byte,
                                                      req_read_line, req_read_col));
         end
      end
      mismatch_count <= mismatch_tally;
      words_in_flight <= expected_words.size();
   end

endmodule

// ----- test/terminal_line_buffer_tb.sv -----
// Testbench top for the terminal line buffer: clock, reset, stimulus and verdict.
module terminal_line_buffer_tb
   import tlb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_TARGET = 1250;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_APPLY;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_read_line = '0;
   logic [5:0]  req_read_col = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_char;
   logic [6:0]  rsp_read_line_length;
   logic [8:0]  rsp_line_count;
   logic [6:0]  rsp_cursor_col;
   logic [31:0] rsp_dropped_total;
   int          mismatch_count;
   int          words_in_flight;
   int          word_count = 0;
   int          cycle_count = 0;
   int          seen_count = 1;
   int          seen_cursor = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   terminal_line_buffer DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .req_read_line(req_read_line),
      .req_read_col(req_read_col),
      .rsp_valid(rsp_valid),
      .rsp_read_char(rsp_read_char),
      .rsp_read_line_length(rsp_read_line_length),
      .rsp_line_count(rsp_line_count),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_dropped_total(rsp_dropped_total)
   );

   terminal_line_buffer_checker line_monitor (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .req_read_line(req_read_line),
      .req_read_col(req_read_col),
      .rsp_valid(rsp_valid),
      .rsp_read_char(rsp_read_char),
      .rsp_read_line_length(rsp_read_line_length),
      .rsp_line_count(rsp_line_count),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_dropped_total(rsp_dropped_total),
      .mismatch_count(mismatch_count),
      .words_in_flight(words_in_flight)
   );

   always @(posedge clock) begin
      if (rsp_valid) begin
         seen_count <= int'(rsp_line_count);
         seen_cursor <= int'(rsp_cursor_col);
      end
   end

   task automatic send_word(input logic mode, input logic [7:0] data,
                            input logic [7:0] line, input logic [5:0] col);
      int idle_pct;
      case ((word_count / 200) % 3)
         0: begin
            idle_pct = 0;
         end
         1: begin
            idle_pct = 66;
         end
         default: begin
            idle_pct = 7;
         end
      endcase
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_data_byte <= data;
      req_read_line <= line;
      req_read_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (mode == MODE_READ || data == BYTE_CR || data == BYTE_LF || data == BYTE_BS ||
          data == BYTE_DEL || data == BYTE_TAB || (data >= PRINT_LO && data <= PRINT_HI)) begin
         word_count++;
      end
   endtask

   task automatic apply_byte(input logic [7:0] data);
      send_word(MODE_APPLY, data, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
   endtask

   task automatic read_char_at(input logic [7:0] line, input logic [5:0] col);
      send_word(MODE_READ, 8'($urandom_range(0, 255)), line, col);
   endtask

   task automatic read_somewhere();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         read_char_at(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      end else if (pick < 40) begin
         read_char_at(8'(seen_count - 1),
                      6'($urandom_range(0, (seen_cursor > 0) ? seen_cursor : 63)));
      end else if (pick < 85) begin
         read_char_at(8'($urandom_range(0, seen_count - 1)), 6'($urandom_range(0, 7)));
      end else begin
         read_char_at(8'($urandom_range(0, seen_count - 1)), 6'($urandom_range(0, 63)));
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (words_in_flight != 0);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int kind;
      int n;
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read_char_at(8'd0, 6'd0);
      read_char_at(8'd255, 6'd63);
      apply_byte(BYTE_BS);
      apply_byte(PRINT_LO);
      apply_byte(PRINT_HI);
      apply_byte(8'h1F);
      apply_byte(8'hFF);
      apply_byte(BYTE_TAB);
      read_char_at(8'd0, 6'd0);
      read_char_at(8'd0, 6'd5);
      read_char_at(8'd0, 6'd6);
      apply_byte(BYTE_BS);
      apply_byte(BYTE_DEL);
      apply_byte(BYTE_CR);
      apply_byte(BYTE_LF);
      apply_byte(BYTE_LF);
      apply_byte(BYTE_CR);
      apply_byte(8'h00);
      apply_byte(BYTE_LF);
      apply_byte(BYTE_BS);
      read_char_at(8'd1, 6'd0);
      read_char_at(8'd0, 6'd63);
      wait_drained();

      while (word_count < WORD_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 8) begin
                  apply_byte(BYTE_TAB);
               end else if (pick < 12) begin
                  apply_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
               end else begin
                  apply_byte(8'($urandom_range(32, 126)));
               end
               if ($urandom_range(0, 3) == 0) begin
                  read_somewhere();
               end
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               apply_byte(BYTE_CR);
               apply_byte(BYTE_LF);
            end else if (pick < 7) begin
               apply_byte(BYTE_CR);
            end else if (pick < 9) begin
               apply_byte(BYTE_LF);
            end
         end else if (kind < 60) begin
            repeat ($urandom_range(1, 6)) read_somewhere();
         end else if (kind < 70) begin
            repeat ($urandom_range(5, 30)) apply_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
         end else if (kind < 80) begin
            repeat ($urandom_range(1, 10)) apply_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 4)) begin
               send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            end
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- terminal_line_buffer.f -----
+incdir+hdl
hdl/tlb_pkg.sv
hdl/tlb_mem.sv
hdl/terminal_line_buffer.sv
test/terminal_line_buffer_checker.sv
test/terminal_line_buffer_tb.sv
